// File: rtl/core/mpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mount-point prefix match package
// Shared constants, payload word types and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mpm_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int PATH_BYTES_DEF  = 64;

    localparam logic [7:0] SLASH_BYTE = 8'h2F;
    localparam logic [7:0] NUL_BYTE   = 8'h00;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    localparam logic FUNC_MOUNT  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic        func;
        logic [7:0]  ch;
        logic [15:0] handle;
    } in_word_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic        found;
        logic [15:0] match_handle;
        logic [6:0]  remaining_offset;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;      // register the incoming word, start of an item
        logic mount;     // perform the mount action on the held word
        logic scan;      // compare held byte against current scan entry
        logic scan_rd;   // issue memory read for the next scan entry
        logic rewind;    // return the entry pointer to the first entry
        logic finish;    // lookup string end: fold into result
        logic emit;      // advance the lookup position, or drive the result strobe at string end
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_lookup;  // current string is a lookup
        logic scan_last;  // current scan entry is the last live one
        logic no_entries; // nothing to scan
        logic is_end;     // held byte is zero
    } dp_stat_t;

endpackage

// File: rtl/core/mpm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/mpm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mount-point prefix match datapath
// Entry storage, per-entry match flags and best-match selection.
// ----------------------------------------------------------------------------
module mpm_datapath #(
    parameter int MAX_ENTRIES = 16,
    parameter int PATH_BYTES  = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mpm_pkg::in_word_t  in_word,
    input  mpm_pkg::dp_cmd_t   cmd,
    output mpm_pkg::dp_stat_t  stat,
    output logic               result,
    output mpm_pkg::out_word_t out_word
);
    import mpm_pkg::*;

    localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int PW = (PATH_BYTES > 1) ? $clog2(PATH_BYTES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int LW = $clog2(PATH_BYTES + 1);
    localparam int AW = EW + PW;

    in_word_t          word_reg;
    logic [CW-1:0]     count_reg;
    logic [LW-1:0]     pos_reg;
    logic              func_reg;
    logic              too_long_reg;
    logic [MAX_ENTRIES-1:0] still_reg;
    logic [MAX_ENTRIES-1:0] full_reg;
    logic [EW-1:0]     scan_reg;     // entry whose byte is on rdata
    logic [EW-1:0]     rd_idx_reg;   // entry address being read
    logic [LW-1:0]     best_len_reg;
    logic [15:0]       best_h_reg;
    logic              best_found_reg;
    logic              result_reg;
    out_word_t         out_reg;

    logic [LW-1:0]     len_tab [MAX_ENTRIES];
    logic [15:0]       hdl_tab [MAX_ENTRIES];

    logic              cur_func;
    logic              free_slot;
    logic              byte_we;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [7:0]        rdata;
    logic [LW-1:0]     scan_len;
    logic [EW-1:0]     fold_idx;

    assign cur_func  = (pos_reg == '0) ? in_word.func : func_reg;
    assign free_slot = (count_reg < CW'(MAX_ENTRIES));
    assign byte_we   = cmd.take && (cur_func == FUNC_MOUNT) && (in_word.ch != NUL_BYTE)
                       && free_slot && (pos_reg < LW'(PATH_BYTES));
    assign waddr     = {count_reg[EW-1:0], pos_reg[PW-1:0]};
    assign raddr     = {rd_idx_reg, pos_reg[PW-1:0]};
    assign scan_len  = len_tab[scan_reg];
    assign fold_idx  = scan_reg;

    mpm_ram #(.WIDTH(8), .DEPTH(MAX_ENTRIES * (1 << PW))) u_bytes (
        .clk   (clk),
        .we    (byte_we),
        .waddr (waddr),
        .wdata (in_word.ch),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign stat.is_lookup  = func_reg;
    assign stat.is_end     = (word_reg.ch == NUL_BYTE);
    assign stat.no_entries = (count_reg == '0);
    assign stat.scan_last  = (CW'(scan_reg) + CW'(1) >= count_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mount && word_reg.ch == NUL_BYTE && free_slot && !too_long_reg
            && pos_reg < LW'(PATH_BYTES))
        begin
            len_tab[count_reg[EW-1:0]] <= pos_reg;
            hdl_tab[count_reg[EW-1:0]] <= word_reg.handle;
        end
        if (cmd.take)
        begin
            word_reg <= in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pos_reg        <= '0;
            func_reg       <= FUNC_MOUNT;
            too_long_reg   <= 1'b0;
            still_reg      <= '1;
            full_reg       <= '0;
            scan_reg       <= '0;
            rd_idx_reg     <= '0;
            best_len_reg   <= '0;
            best_h_reg     <= '0;
            best_found_reg <= 1'b0;
            result_reg     <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            result_reg <= 1'b0;
            if (cmd.take)
            begin
                func_reg   <= cur_func;
                rd_idx_reg <= '0;
                scan_reg   <= '0;
                if (cur_func == FUNC_MOUNT && in_word.ch != NUL_BYTE)
                begin
                    if (pos_reg >= LW'(PATH_BYTES - 1))
                    begin
                        too_long_reg <= 1'b1;
                    end
                end
            end
            if (cmd.scan_rd)
            begin
                rd_idx_reg <= rd_idx_reg + EW'(1);
            end
            if (cmd.rewind)
            begin
                scan_reg <= '0;
            end
            if (cmd.scan)
            begin
                if (still_reg[scan_reg])
                begin
                    if (pos_reg < scan_len)
                    begin
                        if (rdata != word_reg.ch)
                        begin
                            still_reg[scan_reg] <= 1'b0;
                        end
                    end
                    else
                    begin
                        if (pos_reg == scan_len && (word_reg.ch == NUL_BYTE
                            || word_reg.ch == SLASH_BYTE))
                        begin
                            full_reg[scan_reg] <= 1'b1;
                        end
                        still_reg[scan_reg] <= 1'b0;
                    end
                end
                if (!stat.scan_last)
                begin
                    scan_reg <= scan_reg + EW'(1);
                end
            end
            if (cmd.finish)
            begin
                // Walk once more over the entries to fold the winner.
                if (full_reg[fold_idx] && CW'(fold_idx) < count_reg
                    && len_tab[fold_idx] > best_len_reg)
                begin
                    best_len_reg   <= len_tab[fold_idx];
                    best_h_reg     <= hdl_tab[fold_idx];
                    best_found_reg <= 1'b1;
                end
                if (!stat.scan_last)
                begin
                    scan_reg <= scan_reg + EW'(1);
                end
            end
            if (cmd.mount)
            begin
                if (word_reg.ch != NUL_BYTE)
                begin
                    if (pos_reg < LW'(PATH_BYTES))
                    begin
                        pos_reg <= pos_reg + LW'(1);
                    end
                end
                else
                begin
                    result_reg <= 1'b1;
                    if (!free_slot)
                    begin
                        out_reg <= '{FUNC_MOUNT, STATUS_FULL, 1'b0, 16'd0, 7'd0};
                    end
                    else if (too_long_reg || pos_reg >= LW'(PATH_BYTES))
                    begin
                        out_reg <= '{FUNC_MOUNT, STATUS_TOO_LONG, 1'b0, 16'd0, 7'd0};
                    end
                    else
                    begin
                        out_reg   <= '{FUNC_MOUNT, STATUS_OK, 1'b0, 16'd0, 7'd0};
                        count_reg <= count_reg + CW'(1);
                    end
                    pos_reg      <= '0;
                    too_long_reg <= 1'b0;
                    still_reg    <= '1;
                    full_reg     <= '0;
                end
            end
            if (cmd.emit)
            begin
                // End of a lookup byte: advance or report.
                if (word_reg.ch != NUL_BYTE)
                begin
                    if (pos_reg < LW'(PATH_BYTES))
                    begin
                        pos_reg <= pos_reg + LW'(1);
                    end
                end
                else
                begin
                    result_reg            <= 1'b1;
                    out_reg.kind          <= FUNC_LOOKUP;
                    out_reg.status        <= STATUS_OK;
                    out_reg.found         <= best_found_reg;
                    out_reg.match_handle  <= best_found_reg ? best_h_reg : 16'd0;
                    out_reg.remaining_offset <= best_found_reg ?
                        7'(best_len_reg + ((pos_reg > best_len_reg) ? LW'(1) : LW'(0)))
                        : 7'd0;
                    pos_reg        <= '0;
                    too_long_reg   <= 1'b0;
                    still_reg      <= '1;
                    full_reg       <= '0;
                    best_len_reg   <= '0;
                    best_h_reg     <= '0;
                    best_found_reg <= 1'b0;
                end
            end
        end
    end

    assign result   = result_reg;
    assign out_word = out_reg;

endmodule

// File: rtl/core/mpm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mount-point prefix match controller
// Sequences one word: mount action, or a lookup scan (skipped with no entries) and optional fold.
// ----------------------------------------------------------------------------
module mpm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mpm_pkg::dp_stat_t stat,
    output mpm_pkg::dp_cmd_t  cmd,
    output logic              busy
);
    import mpm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_SCAN,
        S_REWIND,
        S_FOLD,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   busy_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.take    = start && !busy_reg;
        case (state_reg)
            S_DECIDE: cmd.mount   = !stat.is_lookup;
            S_READ:   cmd.scan_rd = 1'b1;
            S_SCAN:
            begin
                cmd.scan    = 1'b1;
                cmd.scan_rd = 1'b1;
            end
            S_REWIND: cmd.rewind  = 1'b1;
            S_FOLD:   cmd.finish  = 1'b1;
            S_DONE:   cmd.emit    = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_DECIDE;
                        busy_reg  <= 1'b1;
                    end
                end
                S_DECIDE:
                begin
                    if (!stat.is_lookup)
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                    end
                    else if (stat.no_entries)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:   state_reg <= S_SCAN;
                S_SCAN:
                begin
                    if (stat.scan_last)
                    begin
                        state_reg <= stat.is_end ? S_REWIND : S_DONE;
                    end
                end
                S_REWIND: state_reg <= S_FOLD;
                S_FOLD:
                begin
                    if (stat.scan_last)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy = busy_reg;

endmodule

// File: rtl/core/mount_point_prefix_match_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mount-point prefix match core
// Streams mount and lookup path strings one byte per word and reports the
// longest stored mount point that prefixes each lookup string.
// ----------------------------------------------------------------------------
// Entry bytes are read one entry per cycle from the byte memory, so a lookup
// byte takes longer the more entries are stored, and the closing zero byte of
// a lookup walks the entries a second time to fold the best match. With an
// empty table a lookup byte skips the scan. The result word strobes
// in the first cycle with busy low again; the receiver cannot stall it.
// Reset is asynchronous and empties the table; entry memory is not cleared.
module mount_point_prefix_match_core #(
    parameter int MAX_ENTRIES = mpm_pkg::MAX_ENTRIES_DEF,
    parameter int PATH_BYTES  = mpm_pkg::PATH_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  mpm_pkg::in_word_t  in_word,
    output logic               result_valid,
    output mpm_pkg::out_word_t result
);
    import mpm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The controller owns sequencing; the datapath holds all table state.
    mpm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    mpm_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .PATH_BYTES  (PATH_BYTES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_word),
        .cmd      (cmd),
        .stat     (stat),
        .result   (result_valid),
        .out_word (result)
    );

endmodule

// File: rtl/core/mpm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mount-point prefix match port checker
// Watches the top-level ports for strobe width, busy handshake and field sanity.
// ----------------------------------------------------------------------------
module mpm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               result_valid,
    input mpm_pkg::out_word_t result
);
    import mpm_pkg::*;

    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held longer than one cycle");

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_lookup_status: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == FUNC_LOOKUP) |-> result.status == STATUS_OK)
        else $error("lookup result with nonzero status");

    a_mount_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == FUNC_MOUNT) |->
        (!result.found && result.match_handle == 16'd0 && result.remaining_offset == 7'd0))
        else $error("mount result carries lookup fields");

    a_notfound: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.found) |-> result.remaining_offset == 7'd0)
        else $error("offset without match");

endmodule

bind mount_point_prefix_match_core mpm_checker u_mpm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
